// ----- hw/rtl/tisd_pkg.sv -----
// ----------------------------------------------------------------------------
// tisd_pkg: shared types and constants of the tagged integer stream decoder
// Holds the phase and result kind codes, the tag characters and the
// structs that carry decoder state and one result between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tisd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned ValueW = 64;
    localparam int unsigned CountW = 4;
    // A string length is a positive 64-bit value, so 63 bits hold it.
    localparam int unsigned CharsW = ValueW - 1;

    localparam logic [ByteW-1:0] TagTrue   = 8'h74;  // 't'
    localparam logic [ByteW-1:0] TagFalse  = 8'h66;  // 'f'
    localparam logic [ByteW-1:0] TagChar   = 8'h63;  // 'c'
    localparam logic [ByteW-1:0] TagString = 8'h53;  // 'S'

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_CHAR    = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_STRING  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        K_TRUE   = 3'd0,
        K_FALSE  = 3'd1,
        K_CHAR   = 3'd2,
        K_INT    = 3'd3,
        K_SBYTE  = 3'd4,
        K_SEMPTY = 3'd5
    } t_kind;

    typedef struct packed {
        t_phase              phase;
        logic                is_string;
        logic                wide;        // header gave more than seven payload bytes
        logic [CountW-1:0]   bytes_left;
        logic [ValueW-1:0]   accumulator;
        logic [CharsW-1:0]   chars_left;
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [ValueW-1:0]   value;
        logic                last;
        logic                overflow;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/tisd_step.sv -----
// ----------------------------------------------------------------------------
// tisd_step: one-byte decode step
// Given the current decoder state and one stream byte, forms the next state
// and at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module tisd_step
    import tisd_pkg::*;
(
    input  t_state            i_state,
    input  logic [ByteW-1:0]  i_byte,
    output t_state            o_state,
    output logic              o_res_valid,
    output t_result           o_result
);

    logic [ValueW-1:0] w_acc;
    logic [CountW-1:0] w_left;
    logic              w_finish;
    logic [CharsW-1:0] w_chars_dec;

    assign w_chars_dec = i_state.chars_left - CharsW'(1);

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_result    = '{kind: K_TRUE, value: '0, last: 1'b1, overflow: 1'b0};
        w_acc       = i_state.accumulator;
        w_left      = i_state.bytes_left;
        w_finish    = 1'b0;

        case (i_state.phase)
            PH_CHAR: begin
                o_state.phase  = PH_TAG;
                o_res_valid    = 1'b1;
                o_result.kind  = K_CHAR;
                o_result.value = ValueW'(i_byte);
            end
            PH_HEADER: begin
                w_left = i_byte[7:4];
                w_acc  = {{(ValueW-4){i_byte[3]}}, i_byte[3:0]};
                o_state.wide = i_byte[7];
                if (w_left == '0) begin
                    w_finish = 1'b1;
                end else begin
                    o_state.phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                w_acc  = {i_state.accumulator[ValueW-ByteW-1:0], i_byte};
                w_left = i_state.bytes_left - CountW'(1);
                if (w_left == '0) begin
                    w_finish = 1'b1;
                end
            end
            PH_STRING: begin
                o_state.chars_left = w_chars_dec;
                o_res_valid        = 1'b1;
                o_result.kind      = K_SBYTE;
                o_result.value     = ValueW'(i_byte);
                o_result.last      = (w_chars_dec == '0);
                if (w_chars_dec == '0) begin
                    o_state.phase = PH_TAG;
                end
            end
            default: begin
                o_state.phase = PH_TAG;
                if (i_byte == TagTrue) begin
                    o_res_valid    = 1'b1;
                    o_result.kind  = K_TRUE;
                    o_result.value = ValueW'(1);
                end else if (i_byte == TagFalse) begin
                    o_res_valid   = 1'b1;
                    o_result.kind = K_FALSE;
                end else if (i_byte == TagChar) begin
                    o_state.phase = PH_CHAR;
                end else begin
                    o_state.is_string = (i_byte == TagString);
                    o_state.phase     = PH_HEADER;
                end
            end
        endcase

        o_state.accumulator = w_acc;
        o_state.bytes_left  = w_left;

        // The value is complete: an integer, or the length of a string.
        if (w_finish) begin
            if (!i_state.is_string) begin
                o_state.phase     = PH_TAG;
                o_res_valid       = 1'b1;
                o_result.kind     = K_INT;
                o_result.value    = w_acc;
                o_result.overflow = o_state.wide;
            end else if (w_acc[ValueW-1] || w_acc == '0) begin
                o_state.phase = PH_TAG;
                o_res_valid   = 1'b1;
                o_result.kind = K_SEMPTY;
            end else begin
                o_state.chars_left = w_acc[CharsW-1:0];
                o_state.phase      = PH_STRING;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tagged_integer_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// tagged_integer_stream_decoder_top: serialized tagged value decoder
// Decodes a byte stream of tagged booleans, characters, integers and strings.
// ----------------------------------------------------------------------------
// The block takes one stream byte per transfer on the input channel and gives
// at most one result per byte on the output channel. It sustains one byte per
// clock cycle as long as results are taken: each byte is captured in an input
// register, decoded by one step of short logic (a byte shift into the 64-bit
// accumulator or a 63-bit decrement of the string count) and written to the
// result register, which holds it on the output until it is transferred. Bytes
// that yield no result (tags, headers, inner payload bytes) pass without waiting
// on the output side; a byte that yields a result waits only while the result
// register is still full and not being taken.
`default_nettype none

module tagged_integer_stream_decoder_top
    import tisd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data_byte,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [2:0]             o_kind,
    output logic signed [63:0]     o_value,
    output logic                   o_last,
    output logic                   o_overflow
);

    // Input register.
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;

    // Decoder state and result register.
    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    t_result r_out;
    logic    w_res_valid;
    t_result w_result;
    logic    w_fire;

    tisd_step u_step (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .o_state     (n_state),
        .o_res_valid (w_res_valid),
        .o_result    (w_result)
    );

    // The held byte moves on when it gives no result, or when the result
    // register is free or is being emptied in this cycle.
    assign w_fire  = r_in_valid && (!w_res_valid || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_TAG, default: '0};
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire && w_res_valid) begin
            r_out <= w_result;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out.kind;
    assign o_value    = r_out.value;
    assign o_last     = r_out.last;
    assign o_overflow = r_out.overflow;

endmodule

`default_nettype wire

// ----- hw/rtl/tisd_checker.sv -----
// ----------------------------------------------------------------------------
// tisd_checker: port-level checks of the stream decoder
// Watches the top-level ports and flags results that break the output rules.
// ----------------------------------------------------------------------------
`default_nettype none

module tisd_checker
    import tisd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_kind,
    input wire logic [63:0] o_value,
    input wire logic        o_last,
    input wire logic        o_overflow
);

    // A stalled result holds until its transfer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_value)
            && $stable(o_last) && $stable(o_overflow))
        else $error("stalled result changed");

    // Only an integer can carry the overflow flag.
    a_ovf_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_kind == K_INT)
        else $error("overflow on a non-integer result");

    // Every result other than a string byte is a single, final result.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_SBYTE |-> o_last)
        else $error("single result without last");

    // Characters and string bytes carry a byte value.
    a_byte_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == K_CHAR || o_kind == K_SBYTE) |-> o_value[63:8] == '0)
        else $error("character value out of byte range");

    // Booleans and empty strings carry their fixed values.
    a_fixed_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == K_TRUE || o_kind == K_FALSE || o_kind == K_SEMPTY)
            |-> o_value == ((o_kind == K_TRUE) ? 64'd1 : 64'd0))
        else $error("wrong value on boolean or empty string");

endmodule

bind tagged_integer_stream_decoder_top tisd_checker u_tisd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_kind     (o_kind),
    .o_value    (o_value),
    .o_last     (o_last),
    .o_overflow (o_overflow)
);

`default_nettype wire
